@@ rtl/ssc_pkg.sv @@
// Shared types, constants and the CRC helper for the speed command framer.
package ssc_pkg;

   localparam int AxisWidth   = 16;
   localparam int ByteWidth   = 8;
   localparam int WeightWidth = 9;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 9;
   localparam int PacketLen   = 5;

   localparam logic [CsrIdxWidth-1:0] CsrDeviceAddress   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrSmoothingWeight = 2'd1;

   localparam logic [ByteWidth-1:0]   AddressReset = 8'd128;
   localparam logic [WeightWidth-1:0] WeightReset  = 9'd51;
   localparam logic [WeightWidth-1:0] WeightOne    = 9'd256;

   localparam logic [ByteWidth-1:0] OpForward  = 8'h00;
   localparam logic [ByteWidth-1:0] OpBackward = 8'h01;
   localparam logic [ByteWidth-1:0] SpeedMax   = 8'd127;

   localparam logic [15:0] CrcPoly = 16'h1021;

   // head of one packet, as handed from the front to the serializer
   typedef struct packed {
      logic [ByteWidth-1:0] address;
      logic [ByteWidth-1:0] opcode;
      logic [ByteWidth-1:0] speed;
   } packet_head_type;

   // CRC-16/XMODEM update over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [ByteWidth-1:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/ssc_if.sv @@
// Request and response channel interfaces.
interface ssc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ssc_pkg::AxisWidth-1:0] axis_value;

   modport source (output valid, output axis_value, input ready);
   modport sink   (input valid, input axis_value, output ready);
endinterface

interface ssc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssc_pkg::ByteWidth-1:0] out_byte;
   logic                          last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

@@ rtl/ssc_front.sv @@
// Front end: scales each axis sample to a target speed and smooths it.
module ssc_front (
   input  logic                              clock,
   input  logic                              reset,
   ssc_req_if.sink                           req_chan,
   input  logic [ssc_pkg::ByteWidth-1:0]     device_address,
   input  logic [ssc_pkg::WeightWidth-1:0]   smoothing_weight,
   output logic                              push_valid,
   output ssc_pkg::packet_head_type          push_data,
   input  logic                              push_ready
);

   logic                                  s1_valid_ff, s1_valid_in;
   logic signed [ssc_pkg::AxisWidth-1:0]  axis_ff, axis_in;
   logic                                  s2_valid_ff, s2_valid_in;
   logic signed [ssc_pkg::ByteWidth-1:0]  target_ff, target_in;
   logic signed [ssc_pkg::ByteWidth-1:0]  smoothed_ff, smoothed_in;

   logic s1_free, s2_free, s2_adv;

   // target = round(axis * 127 / 2^15), halves away from zero
   logic [23:0] axis_ext, scaled, scaled_mag, scaled_rnd;
   logic [7:0]  target_mag;

   // next = round((256*prev + w*(target - prev)) / 256)
   logic [ssc_pkg::WeightWidth-1:0] w_sat;
   logic signed [8:0]               diff;
   logic signed [18:0]              product, num;
   logic [18:0]                     num_mag, num_rnd;
   logic [7:0]                      next_mag;
   logic signed [7:0]               next_speed;
   logic                            next_neg;

   assign s2_free = !s2_valid_ff || push_ready;
   assign s1_free = !s1_valid_ff || s2_free;
   assign s2_adv  = s2_valid_ff && push_ready;
   assign req_chan.ready = s1_free;

   always_comb begin
      axis_ext   = {{8{axis_ff[15]}}, axis_ff};
      scaled     = (axis_ext << 7) - axis_ext;
      scaled_mag = scaled[23] ? (24'd0 - scaled) : scaled;
      scaled_rnd = scaled_mag + 24'h004000;
      target_mag = scaled_rnd[22:15];
      target_in  = scaled[23] ? (8'sd0 - $signed(target_mag)) : $signed(target_mag);
   end

   always_comb begin
      w_sat      = (smoothing_weight > ssc_pkg::WeightOne) ? ssc_pkg::WeightOne
                                                           : smoothing_weight;
      diff       = {target_ff[7], target_ff} - {smoothed_ff[7], smoothed_ff};
      product    = $signed({1'b0, w_sat}) * diff;
      num        = $signed({{3{smoothed_ff[7]}}, smoothed_ff, 8'h00}) + product;
      next_neg   = num[18];
      num_mag    = next_neg ? (19'd0 - num) : num;
      num_rnd    = num_mag + 19'd128;
      next_mag   = num_rnd[15:8];
      next_speed = next_neg ? (8'sd0 - $signed(next_mag)) : $signed(next_mag);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      axis_in     = axis_ff;
      s2_valid_in = s2_valid_ff;
      smoothed_in = smoothed_ff;
      if (s1_free) begin
         s1_valid_in = req_chan.valid;
         axis_in     = req_chan.axis_value;
      end
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
      end
      if (s2_adv) begin
         smoothed_in = next_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         smoothed_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         smoothed_ff <= smoothed_in;
      end
      axis_ff <= axis_in;
      if (s2_free) begin
         target_ff <= target_in;
      end
   end

   assign push_valid        = s2_valid_ff;
   assign push_data.address = device_address;
   assign push_data.opcode  = (next_neg && next_mag != 8'd0) ? ssc_pkg::OpBackward
                                                             : ssc_pkg::OpForward;
   assign push_data.speed   = next_mag;

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_data.speed <= ssc_pkg::SpeedMax)
      else $error("speed magnitude out of range");

   a_backward_nonzero: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_data.opcode == ssc_pkg::OpBackward) |-> push_data.speed != 8'd0)
      else $error("backward request with zero speed");

endmodule

@@ rtl/ssc_queue.sv @@
// Small queue between the front end and the byte serializer.
module ssc_queue #(
   parameter int Depth = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  ssc_pkg::packet_head_type  push_data,
   output logic                      push_ready,
   output logic                      pop_valid,
   output ssc_pkg::packet_head_type  pop_data,
   input  logic                      pop_ready
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] Full    = CntW'(Depth);

   ssc_pkg::packet_head_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff != Full;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("queue count overflow");

endmodule

@@ rtl/ssc_back.sv @@
// Back end: serializes each packet head into five bytes with the CRC.
module ssc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   input  ssc_pkg::packet_head_type  pop_data,
   output logic                      pop_ready,
   ssc_rsp_if.source                 rsp_chan
);

   localparam logic [2:0] ByteAddress = 3'd0;
   localparam logic [2:0] ByteOpcode  = 3'd1;
   localparam logic [2:0] ByteSpeed   = 3'd2;
   localparam logic [2:0] ByteCrcHigh = 3'd3;
   localparam logic [2:0] ByteCrcLow  = 3'd4;

   logic [2:0]                    idx_ff, idx_in;
   logic [15:0]                   crc_ff, crc_in;
   logic                          out_valid_ff, out_valid_in;
   logic [ssc_pkg::ByteWidth-1:0] out_byte_ff, out_byte_in;
   logic                          last_ff, last_in;
   logic                          load;

   assign load = pop_valid && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         last_in      = 1'b0;
         idx_in       = idx_ff + 1'b1;
         unique case (idx_ff)
            ByteAddress: begin
               out_byte_in = pop_data.address;
               crc_in      = ssc_pkg::crc_byte(16'h0000, pop_data.address);
            end
            ByteOpcode: begin
               out_byte_in = pop_data.opcode;
               crc_in      = ssc_pkg::crc_byte(crc_ff, pop_data.opcode);
            end
            ByteSpeed: begin
               out_byte_in = pop_data.speed;
               crc_in      = ssc_pkg::crc_byte(crc_ff, pop_data.speed);
            end
            ByteCrcHigh: begin
               out_byte_in = crc_ff[15:8];
            end
            ByteCrcLow: begin
               out_byte_in = crc_ff[7:0];
               last_in     = 1'b1;
               idx_in      = ByteAddress;
            end
            default: begin
               idx_in = ByteAddress;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= ByteAddress;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign pop_ready          = load && idx_ff == ByteCrcLow;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.last_byte = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= ByteCrcLow)
      else $error("byte index out of range");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (load && idx_ff == ByteCrcLow) |=> (idx_ff == ByteAddress && last_ff))
      else $error("packet did not close on crc low byte");

endmodule

@@ rtl/smoothed_speed_command_framer.sv @@
// Top level: CSRs, front end, packet queue and byte serializer.
// Requests pass front stages s1 and s2, the packet queue and the output byte register.
// Bytes leave one a cycle while rsp_chan is ready; the five-byte packets set the rate.
// Requests are accepted while earlier packets drain, up to QueueDepth+3 in flight.
// Synchronous active-high reset: address 128, weight 51, smoothed speed 0, queue empty.
module smoothed_speed_command_framer #(
   parameter int QueueDepth = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   ssc_req_if.sink                           req_chan,
   ssc_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_en,
   input  logic [ssc_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [ssc_pkg::CsrDatWidth-1:0]   csr_write_data
);

   logic [ssc_pkg::ByteWidth-1:0]   device_address_ff, device_address_in;
   logic [ssc_pkg::WeightWidth-1:0] smoothing_weight_ff, smoothing_weight_in;

   logic                     push_valid, push_ready, pop_valid, pop_ready;
   ssc_pkg::packet_head_type push_data, pop_data;

   always_comb begin
      device_address_in   = device_address_ff;
      smoothing_weight_in = smoothing_weight_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ssc_pkg::CsrDeviceAddress:   device_address_in   = csr_write_data[7:0];
            ssc_pkg::CsrSmoothingWeight: smoothing_weight_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff   <= ssc_pkg::AddressReset;
         smoothing_weight_ff <= ssc_pkg::WeightReset;
      end else begin
         device_address_ff   <= device_address_in;
         smoothing_weight_ff <= smoothing_weight_in;
      end
   end

   ssc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .device_address   (device_address_ff),
      .smoothing_weight (smoothing_weight_ff),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .push_ready       (push_ready)
   );

   ssc_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   ssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ test/ssc_frame_checker.sv @@
// Checker for the speed command framer: predicts each packet and compares the bytes.
module ssc_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   ssc_req_if                              req_chan,
   ssc_rsp_if                              rsp_chan,
   input  logic                            csr_write_en,
   input  logic [ssc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [ssc_pkg::CsrDatWidth-1:0] csr_write_data,
   output int                              failures,
   output int                              bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ssc_pkg::ByteWidth-1:0] data;
      logic                          last;
   } frame_byte_type;

   logic [ssc_pkg::ByteWidth-1:0]        address;
   logic [ssc_pkg::WeightWidth-1:0]      weight;
   logic signed [ssc_pkg::ByteWidth-1:0] speed_state;
   frame_byte_type                       packet_bytes_due[$];

   // divide by 2**shift, halves away from zero
   function automatic int round_away(input longint num, input int shift);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + (longint'(1) << (shift - 1))) >> shift;
      return (num < 0) ? -int'(mag) : int'(mag);
   endfunction

   // CRC-16/XMODEM over address, opcode and speed, one bit at a time
   function automatic logic [15:0] header_crc(input logic [3*ssc_pkg::ByteWidth-1:0] msg);
      logic [15:0] crc;
      logic        feedback;
      crc = '0;
      for (int i = 3*ssc_pkg::ByteWidth-1; i >= 0; i--) begin
         feedback = crc[15] ^ msg[i];
         crc = {crc[14:0], 1'b0};
         if (feedback) begin
            crc = crc ^ ssc_pkg::CrcPoly;
         end
      end
      return crc;
   endfunction

   function automatic void queue_byte(input logic [ssc_pkg::ByteWidth-1:0] data,
                                      input logic last);
      frame_byte_type entry;
      entry.data = data;
      entry.last = last;
      packet_bytes_due.insert(packet_bytes_due.size(), entry);
   endfunction

   task automatic frame_command(input logic signed [ssc_pkg::AxisWidth-1:0] axis);
      int                            target;
      int                            w;
      int                            next;
      logic [ssc_pkg::ByteWidth-1:0] opcode;
      logic [ssc_pkg::ByteWidth-1:0] magnitude;
      logic [15:0]                   crc;
      target = round_away(longint'(axis) * longint'(ssc_pkg::SpeedMax), 15);
      w = (weight > ssc_pkg::WeightOne) ? int'(ssc_pkg::WeightOne) : int'(weight);
      next = round_away(longint'(w) * target
                        + longint'(int'(ssc_pkg::WeightOne) - w) * longint'(speed_state),
                        8);
      speed_state = next[ssc_pkg::ByteWidth-1:0];
      opcode    = (next >= 0) ? ssc_pkg::OpForward : ssc_pkg::OpBackward;
      magnitude = (next >= 0) ? next[ssc_pkg::ByteWidth-1:0] : 8'(-next);
      crc = header_crc({address, opcode, magnitude});
      queue_byte(address,   1'b0);
      queue_byte(opcode,    1'b0);
      queue_byte(magnitude, 1'b0);
      queue_byte(crc[15:8], 1'b0);
      queue_byte(crc[7:0],  1'b1);
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      failures++;
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         address     = ssc_pkg::AddressReset;
         weight      = ssc_pkg::WeightReset;
         speed_state = '0;
         failures    = 0;
         packet_bytes_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               ssc_pkg::CsrDeviceAddress: begin
                  address = csr_write_data[ssc_pkg::ByteWidth-1:0];
               end
               ssc_pkg::CsrSmoothingWeight: begin
                  weight = csr_write_data[ssc_pkg::WeightWidth-1:0];
               end
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            frame_command(req_chan.axis_value);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (packet_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %b",
                                         rsp_chan.out_byte, rsp_chan.last_byte));
            end else begin
               want = packet_bytes_due.pop_front();
               if (rsp_chan.out_byte !== want.data) begin
                  report_mismatch($sformatf("out_byte got %02h want %02h",
                                            rsp_chan.out_byte, want.data));
               end
               if (rsp_chan.last_byte !== want.last) begin
                  report_mismatch($sformatf("last_byte got %b want %b",
                                            rsp_chan.last_byte, want.last));
               end
            end
         end
      end
      bytes_pending = packet_bytes_due.size();
   end

endmodule

@@ test/tb_smoothed_speed_command_framer.sv @@
// Testbench top for the speed command framer: clock, reset, stimulus and verdict.
module tb_smoothed_speed_command_framer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit    = 400000;
   localparam int RandomPhases  = 8;
   localparam int ItemsPerPhase = 60;

   // indexes past the register list; writes there must be ignored
   localparam logic [ssc_pkg::CsrIdxWidth-1:0] CsrSpareLow  = 2'd2;
   localparam logic [ssc_pkg::CsrIdxWidth-1:0] CsrSpareHigh = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_en;
   logic [ssc_pkg::CsrIdxWidth-1:0] csr_index;
   logic [ssc_pkg::CsrDatWidth-1:0] csr_write_data;

   int failures;
   int bytes_pending;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int cycle_count   = 0;

   logic signed [ssc_pkg::AxisWidth-1:0] last_axis = '0;

   // full scale, zero, rounding halves of the scaling, small targets
   int directed_default[12] = '{32767, 32767, -32768, -32768, 0, 16384,
                                -16384, 1, -1, 128, -129, 258};
   // weight 128 turns the smoothing into (target + previous) / 2
   int directed_half[8] = '{32767, -16384, 16384, 258, -258, 0, -32768, 32767};
   int phase_weights[RandomPhases] = '{0, 256, 511, 257, 1, 255, 128, 51};

   ssc_req_if req_chan();
   ssc_rsp_if rsp_chan();

   smoothed_speed_command_framer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   ssc_frame_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .failures       (failures),
      .bytes_pending  (bytes_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_csr(input logic [ssc_pkg::CsrIdxWidth-1:0] idx, input int value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= ssc_pkg::CsrDatWidth'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_axis(input logic signed [ssc_pkg::AxisWidth-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid      <= 1'b0;
         req_chan.axis_value <= ssc_pkg::AxisWidth'($urandom);
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.axis_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      last_axis = value;
      @(negedge clock);
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
   endtask

   // extremes, near-zero, repeats to drive the smoothed speed to its limits, uniform
   function automatic logic signed [ssc_pkg::AxisWidth-1:0] random_axis();
      case ($urandom_range(7)) inside
         0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1: return ssc_pkg::AxisWidth'(int'($urandom_range(600)) - 300);
         [2:3]: return last_axis;
         default: return ssc_pkg::AxisWidth'($urandom);
      endcase
   endfunction

   initial begin
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_chan.valid      = 1'b0;
      req_chan.axis_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_default[i]) send_axis(ssc_pkg::AxisWidth'(directed_default[i]));
      drain();

      write_csr(ssc_pkg::CsrDeviceAddress, 8'h00);
      write_csr(ssc_pkg::CsrSmoothingWeight, 128);
      write_csr(CsrSpareLow, 9'h1FF);
      write_csr(CsrSpareHigh, 9'h0AA);
      foreach (directed_half[i]) send_axis(ssc_pkg::AxisWidth'(directed_half[i]));
      drain();

      for (int p = 0; p < RandomPhases; p++) begin
         case (p % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 86;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 86;
            end
            default: begin
               req_idle_pct  = 8;
               rsp_stall_pct = 8;
            end
         endcase
         write_csr(ssc_pkg::CsrDeviceAddress,
                   (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : int'($urandom_range(255)));
         write_csr(ssc_pkg::CsrSmoothingWeight,
                   (p == RandomPhases - 1) ? int'($urandom_range(511)) : phase_weights[p]);
         repeat (ItemsPerPhase) send_axis(random_axis());
         drain();
      end

      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
